// ----- hw/rtl/cubic_bezier_flattener_unit_macros.svh -----
// assertion macros used by the flattener top level
`ifndef CUBIC_BEZIER_FLATTENER_UNIT_MACROS_SVH
`define CUBIC_BEZIER_FLATTENER_UNIT_MACROS_SVH

// same-cycle implication
`define CBF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define CBF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/cbf_pkg.sv -----
// shared constants and types of the bezier flattener
package cbf_pkg;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int WEIGHT_BITS     = 17;
    localparam int SCALE_SHIFT     = 8;
    localparam int DIV_STEPS       = 17;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [7:0] SPU_RESET = 8'd64;
    localparam logic       REG_SPU   = 1'b0;

    typedef struct packed {
        logic done;
        logic begins;
    } t_hand;
endpackage

// ----- hw/rtl/cbf_isqrt.sv -----
// bit-serial integer square root, two operand bits per step
module cbf_isqrt import cbf_pkg::*; #(
    parameter int RW = 18
) (
    input  logic            i_clk,
    input  logic            i_start,
    input  logic            i_step,
    input  logic [2*RW-1:0] i_op,
    output logic [RW-1:0]   o_root
);
    logic [2*RW-1:0] r_x;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+1:0]   w_rem2;
    logic [RW+1:0]   w_trial;

    assign w_rem2  = {r_rem[RW-1:0], r_x[2*RW-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_op;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_step) begin
            r_x <= {r_x[2*RW-3:0], 2'b00};
            if (w_rem2 >= w_trial) begin
                r_rem  <= w_rem2 - w_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end
endmodule

// ----- hw/rtl/cbf_setup.sv -----
// per-curve setup: polygon length, sample count and step quotient
module cbf_setup import cbf_pkg::*; #(
    parameter int CW   = COORD_WIDTH_DEF,
    parameter int MAXS = MAX_SAMPLES_DEF,
    localparam int NW  = $clog2(MAXS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0][CW-1:0]   i_pts,
    input  logic                 i_begins,
    input  logic [7:0]           i_spu,
    input  logic                 i_take,
    output t_hand                o_hand,
    output logic [7:0][CW-1:0]   o_pts,
    output logic [NW-1:0]        o_n,
    output logic [WEIGHT_BITS-1:0] o_q,
    output logic [NW-1:0]        o_r
);
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW + 1;
    localparam int RW   = (SQW + 1) / 2;
    localparam int TW   = RW + 2;
    localparam int PW   = TW + 8;
    localparam int CNTW = $clog2(RW + DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIFF, S_SQR, S_ROOT, S_SUM, S_SCALE, S_DIV, S_DONE
    } t_state;

    t_state                 r_state;
    logic [CNTW-1:0]        r_cnt;
    logic [7:0][CW-1:0]     r_pts;
    logic                   r_begins;
    logic [5:0][DW-1:0]     r_d;
    logic [TW-1:0]          r_total;
    logic [NW-1:0]          r_n;
    logic [WEIGHT_BITS-1:0] r_q;
    logic [NW-1:0]          r_rem;
    logic [2:0][2*RW-1:0]   w_sq;
    logic [2:0][RW-1:0]     w_root;
    logic [PW-1:0]          w_prod;
    logic [TW-1:0]          w_nraw;
    logic [NW:0]            w_rsh;
    logic                   w_start;
    logic                   w_step;

    assign w_start = (r_state == S_SQR);
    assign w_step  = (r_state == S_ROOT);

    always_comb begin
        for (int m = 0; m < 3; m++) begin
            w_sq[m] = (2*RW)'(r_d[2*m]) * (2*RW)'(r_d[2*m])
                    + (2*RW)'(r_d[2*m+1]) * (2*RW)'(r_d[2*m+1]);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_root
        cbf_isqrt #(.RW(RW)) u_isqrt (
            .i_clk   (i_clk),
            .i_start (w_start),
            .i_step  (w_step),
            .i_op    (w_sq[g]),
            .o_root  (w_root[g])
        );
    end

    assign w_prod = PW'(r_total) * PW'(i_spu);
    assign w_nraw = w_prod[PW-1:SCALE_SHIFT];
    assign w_rsh  = {r_rem, (r_cnt == '0) ? 1'b1 : 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pts    <= i_pts;
                        r_begins <= i_begins;
                        r_state  <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    for (int j = 0; j < 6; j++) begin
                        logic signed [DW-1:0] v_d;
                        v_d = $signed({r_pts[j][CW-1], r_pts[j]})
                            - $signed({r_pts[j+2][CW-1], r_pts[j+2]});
                        r_d[j] <= v_d[DW-1] ? DW'(-v_d) : DW'(v_d);
                    end
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(RW - 1)) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_total <= TW'(w_root[0]) + TW'(w_root[1]) + TW'(w_root[2]);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (w_nraw < TW'(2)) begin
                        r_n <= NW'(2);
                    end else if (w_nraw > TW'(MAXS)) begin
                        r_n <= NW'(MAXS);
                    end else begin
                        r_n <= w_nraw[NW-1:0];
                    end
                    r_cnt   <= '0;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_rsh >= {1'b0, r_n}) begin
                        r_rem <= NW'(w_rsh - {1'b0, r_n});
                        r_q   <= {r_q[WEIGHT_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh[NW-1:0];
                        r_q   <= {r_q[WEIGHT_BITS-2:0], 1'b0};
                    end
                    if (r_cnt == CNTW'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_hand.done   = (r_state == S_DONE);
    assign o_hand.begins = r_begins;
    assign o_pts         = r_pts;
    assign o_n           = r_n;
    assign o_q           = r_q;
    assign o_r           = r_rem;
endmodule

// ----- hw/rtl/cbf_eval.sv -----
// five-stage bernstein evaluation pipeline, the last stage being the output register
module cbf_eval import cbf_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [WEIGHT_BITS-1:0] i_s,
    input  logic [7:0][CW-1:0]     i_pts,
    input  logic                   i_new,
    input  logic                   i_first,
    input  logic                   i_last,
    input  logic                   i_ready,
    output logic                   o_en,
    output logic                   o_valid,
    output logic [CW-1:0]          o_from_x,
    output logic [CW-1:0]          o_from_y,
    output logic [CW-1:0]          o_to_x,
    output logic [CW-1:0]          o_to_y,
    output logic                   o_new,
    output logic                   o_last
);
    localparam int WB = WEIGHT_BITS;
    localparam int PB = 3 * WB;
    localparam int MB = CW + WB + 1;
    localparam int SB = MB + 2;

    logic [4:0]             r_v;
    logic [3:0][2:0]        r_meta;
    logic [3:0][7:0][CW-1:0] r_pts;
    logic [WB-1:0]          r1_t, r1_s;
    logic [2*WB-1:0]        r1_tt, r1_ts;
    logic [PB-1:0]          r2_a, r2_b, r2_c;
    logic [3:0][WB-1:0]     r3_w;
    logic signed [7:0][MB-1:0] r4_m;
    logic [CW-1:0]          r_prev_x, r_prev_y;
    logic [PB-1:0]          w_b3, w_c3;
    logic [WB-1:0]          w_a, w_b, w_c;
    logic signed [SB-1:0]   w_sx, w_sy;
    logic [CW-1:0]          w_to_x, w_to_y;
    logic [WB-1:0]          w_t;

    assign o_en = !r_v[4] || i_ready;
    assign w_t  = WEIGHT_ONE - i_s;
    assign w_b3 = {r2_b[PB-2:0], 1'b0} + r2_b;
    assign w_c3 = {r2_c[PB-2:0], 1'b0} + r2_c;
    assign w_a  = r2_a[32 +: WB];
    assign w_b  = w_b3[32 +: WB];
    assign w_c  = w_c3[32 +: WB];

    always_comb begin
        w_sx = SB'(32768);
        w_sy = SB'(32768);
        for (int k = 0; k < 4; k++) begin
            w_sx = w_sx + SB'($signed(r4_m[2*k]));
            w_sy = w_sy + SB'($signed(r4_m[2*k+1]));
        end
    end
    assign w_to_x = w_sx[CW+15:16];
    assign w_to_y = w_sy[CW+15:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (o_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_meta[0] <= {i_new, i_first, i_last};
            r_pts[0]  <= i_pts;
            r1_t      <= w_t;
            r1_s      <= i_s;
            r1_tt     <= (2*WB)'(w_t) * (2*WB)'(w_t);
            r1_ts     <= (2*WB)'(w_t) * (2*WB)'(i_s);

            r_meta[1] <= r_meta[0];
            r_pts[1]  <= r_pts[0];
            r2_a      <= PB'(r1_t) * PB'(r1_tt);
            r2_b      <= PB'(r1_t) * PB'(r1_ts);
            r2_c      <= PB'(r1_s) * PB'(r1_ts);

            r_meta[2] <= r_meta[1];
            r_pts[2]  <= r_pts[1];
            r3_w[0]   <= w_a;
            r3_w[1]   <= w_b;
            r3_w[2]   <= w_c;
            r3_w[3]   <= WEIGHT_ONE - w_a - w_b - w_c;

            r_meta[3] <= r_meta[2];
            r_pts[3]  <= r_pts[2];
            for (int k = 0; k < 4; k++) begin
                for (int ax = 0; ax < 2; ax++) begin
                    r4_m[2*k+ax] <= MB'($signed({1'b0, r3_w[k]})
                                      * $signed(r_pts[2][2*k+ax]));
                end
            end

            if (r_v[3]) begin
                o_from_x <= r_meta[3][1] ? r_pts[3][0] : r_prev_x;
                o_from_y <= r_meta[3][1] ? r_pts[3][1] : r_prev_y;
                o_to_x   <= w_to_x;
                o_to_y   <= w_to_y;
                o_new    <= r_meta[3][2];
                o_last   <= r_meta[3][0];
                r_prev_x <= w_to_x;
                r_prev_y <= w_to_y;
            end
        end
    end

    assign o_valid = r_v[4];
endmodule

// ----- hw/rtl/cubic_bezier_flattener_unit.sv -----
// Flattens one cubic bezier curve per input transaction into N line segments,
// N = control polygon length times samples_per_unit / 256, clamped to 2..MAX_SAMPLES.
// Segments leave at one per cycle, unless m_tready holds them back, from a five-stage
// evaluation pipeline, while the next curve's setup (bit-serial square roots, then a
// 17-step divide) overlaps the emission of the current one. After setup hands over,
// the first sample goes from the sequencer registers through the pipeline stages.
module cubic_bezier_flattener_unit import cbf_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int OUT_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [8*COORD_WIDTH-1:0] s_tdata,  // p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y
    input  logic                     s_tuser,  // begins_path
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata,  // from_x from_y to_x to_y, zero pad
    output logic                     m_tuser,  // new_path
    output logic                     m_tlast   // last_segment
);
`include "cubic_bezier_flattener_unit_macros.svh"
    localparam int CW = COORD_WIDTH;
    localparam int NW = $clog2(MAX_SAMPLES + 1);

    logic [7:0]             r_spu;
    t_hand                  w_hand;
    logic [7:0][CW-1:0]     w_in_pts, w_su_pts;
    logic [NW-1:0]          w_su_n, w_su_r;
    logic [WEIGHT_BITS-1:0] w_su_q;
    logic                   w_take;

    logic                   r_busy;
    logic [NW-1:0]          r_idx, r_n, r_r0, r_r;
    logic [WEIGHT_BITS-1:0] r_q0, r_q;
    logic [7:0][CW-1:0]     r_pts;
    logic                   r_begins;
    logic                   w_en, w_issue, w_last, w_ge;
    logic [NW-1:0]          w_idx_nx;
    logic [NW:0]            w_rsum;
    logic [WEIGHT_BITS-1:0] w_s;
    logic [CW-1:0]          w_from_x, w_from_y, w_to_x, w_to_y;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPU) ? {24'd0, r_spu} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spu <= SPU_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SPU) begin
            r_spu <= pwdata[7:0];
        end
    end

    assign w_in_pts = s_tdata;

    cbf_setup #(.CW(CW), .MAXS(MAX_SAMPLES)) u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_pts    (w_in_pts),
        .i_begins (s_tuser),
        .i_spu    (r_spu),
        .i_take   (w_take),
        .o_hand   (w_hand),
        .o_pts    (w_su_pts),
        .o_n      (w_su_n),
        .o_q      (w_su_q),
        .o_r      (w_su_r)
    );

    // sample sequencer: s = floor(i * 65536 / N) for i = 1..N, built incrementally
    assign w_take   = !r_busy && w_hand.done;
    assign w_issue  = r_busy && w_en;
    assign w_idx_nx = r_idx + 1'b1;
    assign w_last   = (w_idx_nx == r_n);
    assign w_rsum   = {1'b0, r_r} + {1'b0, r_r0};
    assign w_ge     = (w_rsum >= {1'b0, r_n});
    assign w_s      = r_q + r_q0 + WEIGHT_BITS'(w_ge);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_n    <= NW'(2);
        end else if (w_take) begin
            r_busy   <= 1'b1;
            r_idx    <= '0;
            r_n      <= w_su_n;
            r_q0     <= w_su_q;
            r_r0     <= w_su_r;
            r_q      <= '0;
            r_r      <= '0;
            r_pts    <= w_su_pts;
            r_begins <= w_hand.begins;
        end else if (w_issue) begin
            r_idx  <= w_idx_nx;
            r_q    <= w_s;
            r_r    <= w_ge ? NW'(w_rsum - {1'b0, r_n}) : w_rsum[NW-1:0];
            r_busy <= !w_last;
        end
    end

    cbf_eval #(.CW(CW)) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_issue),
        .i_s      (w_s),
        .i_pts    (r_pts),
        .i_new    (r_begins && r_idx == '0),
        .i_first  (r_idx == '0),
        .i_last   (w_last),
        .i_ready  (m_tready),
        .o_en     (w_en),
        .o_valid  (m_tvalid),
        .o_from_x (w_from_x),
        .o_from_y (w_from_y),
        .o_to_x   (w_to_x),
        .o_to_y   (w_to_y),
        .o_new    (m_tuser),
        .o_last   (m_tlast)
    );

    assign m_tdata = OUT_W'({w_to_y, w_to_x, w_from_y, w_from_x});

    `CBF_ASSERT_IMP(a_idx_in_range, i_clk, i_rst_n, r_busy, r_idx < r_n)
    `CBF_ASSERT_IMP(a_n_clamped, i_clk, i_rst_n, r_busy, r_n >= NW'(2) && r_n <= NW'(MAX_SAMPLES))
    `CBF_ASSERT_NXT(a_one_curve_in_setup, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
    `CBF_ASSERT_NXT(a_last_frees_seq, i_clk, i_rst_n, w_issue && w_last, !r_busy)
endmodule
